FILE: hdl/pve_pkg.sv
// Shared types, marker constants and header helper for the PackStream encoder.
package pve_pkg;

  typedef enum logic [3:0] {
    CMD_NULL   = 4'd0,
    CMD_BOOL   = 4'd1,
    CMD_INT    = 4'd2,
    CMD_FLOAT  = 4'd3,
    CMD_STRING = 4'd4,
    CMD_BYTES  = 4'd5,
    CMD_LIST   = 4'd6,
    CMD_DICT   = 4'd7,
    CMD_STRUCT = 4'd8,
    CMD_RAW    = 4'd9
  } cmd_e;

  localparam logic [7:0] MRK_NULL  = 8'hC0;
  localparam logic [7:0] MRK_FLOAT = 8'hC1;
  localparam logic [7:0] MRK_FALSE = 8'hC2;
  localparam logic [7:0] MRK_TRUE  = 8'hC3;
  localparam logic [7:0] MRK_INT8  = 8'hC8;
  localparam logic [7:0] MRK_INT16 = 8'hC9;
  localparam logic [7:0] MRK_INT32 = 8'hCA;
  localparam logic [7:0] MRK_INT64 = 8'hCB;

  localparam logic [7:0] MRK_STR_TINY = 8'h80;
  localparam logic [7:0] MRK_STR8     = 8'hD0;
  localparam logic [7:0] MRK_STR16    = 8'hD1;
  localparam logic [7:0] MRK_STR32    = 8'hD2;
  localparam logic [7:0] MRK_BYT8     = 8'hCC;
  localparam logic [7:0] MRK_BYT16    = 8'hCD;
  localparam logic [7:0] MRK_BYT32    = 8'hCE;
  localparam logic [7:0] MRK_LST_TINY = 8'h90;
  localparam logic [7:0] MRK_LST8     = 8'hD4;
  localparam logic [7:0] MRK_LST16    = 8'hD5;
  localparam logic [7:0] MRK_LST32    = 8'hD6;
  localparam logic [7:0] MRK_DCT_TINY = 8'hA0;
  localparam logic [7:0] MRK_DCT8     = 8'hD8;
  localparam logic [7:0] MRK_DCT16    = 8'hD9;
  localparam logic [7:0] MRK_DCT32    = 8'hDA;
  localparam logic [7:0] MRK_STC_TINY = 8'hB0;
  localparam logic [7:0] MRK_STC8     = 8'hDC;
  localparam logic [7:0] MRK_STC16    = 8'hDD;
  localparam logic [7:0] MRK_STC32    = 8'hDE;

  // One encoding job: marker byte, then nbytes bytes taken from the top of data.
  typedef struct packed {
    logic [7:0]  marker;
    logic [63:0] data;
    logic [3:0]  nbytes;
  } pve_desc_t;

  typedef struct packed {
    logic busy;
  } pve_back_stat_t;

  // Sized header: tiny form when allowed and len <= 15, else 8/16/32-bit length, plus a tag byte when has_tag is set.
  function automatic pve_desc_t sized_desc(logic [31:0] len, logic has_tiny,
                                           logic [7:0] m_tiny, logic [7:0] m8,
                                           logic [7:0] m16, logic [7:0] m32,
                                           logic has_tag, logic [7:0] tag);
    pve_desc_t  d;
    logic [3:0] n;
    d.data = '0;
    if (has_tiny && (len <= 32'd15)) begin
      d.marker = m_tiny | {4'b0000, len[3:0]};
      n = 4'd0;
    end else if (len <= 32'hFF) begin
      d.marker = m8;
      d.data[63:56] = len[7:0];
      n = 4'd1;
    end else if (len <= 32'hFFFF) begin
      d.marker = m16;
      d.data[63:48] = len[15:0];
      n = 4'd2;
    end else begin
      d.marker = m32;
      d.data[63:32] = len;
      n = 4'd4;
    end
    if (has_tag) begin
      d.data = d.data | ({tag, 56'd0} >> {n, 3'b000});
      n = n + 4'd1;
    end
    d.nbytes = n;
    return d;
  endfunction

endpackage

FILE: hdl/pve_if.sv
// Valid/ready channel interfaces for encoder commands and output bytes.
interface pve_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [63:0] value;
  logic [31:0]        length;
  logic [7:0]         tag;

  modport source (output valid, command, value, length, tag, input ready);
  modport sink   (input valid, command, value, length, tag, output ready);
endinterface

interface pve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: hdl/pve_front.sv
// Command classifier: picks the encoding form and builds a descriptor.
module pve_front (
  pve_in_if.sink               in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output pve_pkg::pve_desc_t   push_desc_o
);
  import pve_pkg::*;

  logic signed [63:0] v;
  pve_desc_t          d;
  logic               known;

  assign v = in_i.value;

  always_comb begin
    d       = '0;
    known   = 1'b1;
    unique case (in_i.command)
      CMD_NULL: d.marker = MRK_NULL;
      CMD_BOOL: d.marker = v[0] ? MRK_TRUE : MRK_FALSE;
      CMD_INT: begin
        if ((v >= -64'sd16) && (v <= 64'sd127)) begin
          d.marker = v[7:0];
        end else if ((v >= -64'sd128) && (v < 64'sd0)) begin
          d.marker = MRK_INT8;
          d.data[63:56] = v[7:0];
          d.nbytes = 4'd1;
        end else if ((v >= -64'sd32768) && (v <= 64'sd32767)) begin
          d.marker = MRK_INT16;
          d.data[63:48] = v[15:0];
          d.nbytes = 4'd2;
        end else if ((v >= -64'sd2147483648) && (v <= 64'sd2147483647)) begin
          d.marker = MRK_INT32;
          d.data[63:32] = v[31:0];
          d.nbytes = 4'd4;
        end else begin
          d.marker = MRK_INT64;
          d.data   = v;
          d.nbytes = 4'd8;
        end
      end
      CMD_FLOAT: begin
        d.marker = MRK_FLOAT;
        d.data   = v;
        d.nbytes = 4'd8;
      end
      CMD_STRING: d = sized_desc(in_i.length, 1'b1, MRK_STR_TINY, MRK_STR8,
                                 MRK_STR16, MRK_STR32, 1'b0, in_i.tag);
      CMD_BYTES:  d = sized_desc(in_i.length, 1'b0, 8'h00, MRK_BYT8,
                                 MRK_BYT16, MRK_BYT32, 1'b0, in_i.tag);
      CMD_LIST:   d = sized_desc(in_i.length, 1'b1, MRK_LST_TINY, MRK_LST8,
                                 MRK_LST16, MRK_LST32, 1'b0, in_i.tag);
      CMD_DICT:   d = sized_desc(in_i.length, 1'b1, MRK_DCT_TINY, MRK_DCT8,
                                 MRK_DCT16, MRK_DCT32, 1'b0, in_i.tag);
      CMD_STRUCT: d = sized_desc(in_i.length, 1'b1, MRK_STC_TINY, MRK_STC8,
                                 MRK_STC16, MRK_STC32, 1'b1, in_i.tag);
      CMD_RAW:    d.marker = v[7:0];
      default:    known = 1'b0;  // unused codes produce no bytes
    endcase
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && known;
  assign push_desc_o  = d;

endmodule

FILE: hdl/pve_queue.sv
// Small descriptor queue between classifier and byte serializer.
module pve_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  pve_pkg::pve_desc_t   push_desc_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output pve_pkg::pve_desc_t   pop_desc_o
);
  import pve_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pve_desc_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_desc_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

FILE: hdl/pve_back.sv
// Byte serializer: marker first, then data bytes from the top, into an output register.
module pve_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  pve_pkg::pve_desc_t       pop_desc_i,
  pve_out_if.source                out_o,
  output pve_pkg::pve_back_stat_t  stat_o
);
  import pve_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        last_q, last_d;
  logic [63:0] shift_q, shift_d;
  logic [3:0]  rem_q, rem_d;
  logic        adv, busy;

  assign adv  = !out_valid_q || out_o.ready;
  assign busy = (rem_q != 4'd0);
  assign pop_ready_o = adv && !busy;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    if (adv) begin
      if (busy) begin
        out_valid_d = 1'b1;
        out_byte_d  = shift_q[63:56];
        last_d      = (rem_q == 4'd1);
        shift_d     = {shift_q[55:0], 8'h00};
        rem_d       = rem_q - 4'd1;
      end else if (pop_valid_i) begin
        out_valid_d = 1'b1;
        out_byte_d  = pop_desc_i.marker;
        last_d      = (pop_desc_i.nbytes == 4'd0);
        shift_d     = pop_desc_i.data;
        rem_d       = pop_desc_i.nbytes;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    shift_q    <= shift_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = last_q;
  assign stat_o.busy    = busy;

endmodule

FILE: hdl/packstream_value_encoder_top.sv
// Top level of the PackStream v1 value encoder.
// Serializes one command per transaction into PackStream bytes, most
// significant first, one byte per output transaction with last set on the
// final byte of each command. An item yields 1 to 9 bytes (marker plus up to
// eight data bytes; a struct header adds its tag byte); the serializer emits
// one byte per cycle while the output is ready. Commands are classified in the
// cycle they are accepted and land in a descriptor queue of QUEUE_DEPTH
// entries, so new commands keep flowing in while earlier ones drain;
// sustained throughput is set by the byte output, one byte per clock while
// the output is ready. Unused command codes (10..15) are accepted and
// dropped without output. No configuration, no state across commands, no
// warm-up after reset.
module packstream_value_encoder_top #(
  parameter int QUEUE_DEPTH = 2  // descriptor queue entries, 2 or more
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pve_in_if.sink     in_i,
  pve_out_if.source  out_o
);
  import pve_pkg::*;

  // front -> queue
  logic           push_valid, push_ready;
  pve_desc_t      push_desc;
  // queue -> back
  logic           pop_valid, pop_ready;
  pve_desc_t      pop_desc;
  pve_back_stat_t back_stat;

  // Classifier: picks marker and operand bytes per command.
  pve_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  // Decouples acceptance from byte output.
  pve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  // Serializer with registered output byte.
  pve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_desc_i  (pop_desc),
    .out_o       (out_o),
    .stat_o      (back_stat)
  );

`ifndef SYNTHESIS
  // Unused command codes must never reach the queue.
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.command > CMD_RAW)) |-> !push_valid)
    else $error("unused command pushed into queue");

  // The serializer takes no new descriptor while bytes of the current one remain.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.busy |-> !(pop_valid && pop_ready))
    else $error("descriptor popped mid-item");

  // Bytes of one item go out without gaps.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> out_o.valid)
    else $error("gap inside an encoded item");
`endif

endmodule

FILE: tb/packstream_value_encoder_top_tb.sv
// Self-checking testbench for the PackStream value encoder top level.
`timescale 1ns / 100ps

module packstream_value_encoder_top_tb;
  import pve_pkg::*;

  localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
  localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

  localparam int N_DIRECTED     = 25;
  localparam int N_RANDOM       = 100;
  localparam int HOLD_AT        = 30;   // random items sent before the long output hold-off
  localparam int DRAIN_AT       = 60;   // random items sent before the full input pause
  localparam int QUIET_AT       = 85;   // from here on neither side idles
  localparam int RX_HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES    = 32;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_NS     = 2_000_000;

  // One command with its operands. n_typed < 0: expected bytes come from
  // the predictor; otherwise the low n_typed bytes of typed, first byte on top.
  typedef struct {
    logic [3:0]  cmd;
    logic [63:0] value;
    logic [31:0] len;
    logic [7:0]  tag;
    int          n_typed;
    logic [71:0] typed;
  } enc_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } enc_byte_t;

  logic clk_i;
  logic rst_ni;

  pve_in_if  in_if ();
  pve_out_if out_if ();

  packstream_value_encoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  enc_cmd_t   cmds_in_flight[$];  // offered to the block, not yet accepted
  enc_byte_t  enc_bytes_due[$];   // serialized bytes still owed by the block
  logic [7:0] enc_scratch[$];

  int        mismatches    = 0;
  int        cmds_accepted = 0;
  int        bytes_checked = 0;
  int        items_sent    = 0;
  bit [15:0] codes_seen    = '0;

  bit tail_quiet  = 1'b0;  // no idling on either side
  bit tx_no_gap   = 1'b0;  // sender keeps offering back to back
  bit rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
  int tx_gap_pct  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d bytes still due", enc_bytes_due.size());
    $display("packstream_value_encoder_top_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: rebuilds the PackStream byte string for one accepted command.
  // ---------------------------------------------------------------------------
  function automatic void put_be(logic [63:0] x, int n);
    for (int i = n - 1; i >= 0; i--) enc_scratch.insert(enc_scratch.size(), x[8*i +: 8]);
  endfunction

  // Header with a length or count: tiny marker when the type has one and the
  // count fits in the low nibble, else the smallest 8/16/32-bit length form.
  function automatic void put_sized(logic [31:0] len, bit has_tiny, logic [7:0] m_tiny,
                                    logic [7:0] m8, logic [7:0] m16, logic [7:0] m32);
    if (has_tiny && len <= 32'd15) begin
      enc_scratch.insert(enc_scratch.size(), m_tiny | len[7:0]);
    end else if (len <= 32'hFF) begin
      enc_scratch.insert(enc_scratch.size(), m8);
      put_be(64'(len), 1);
    end else if (len <= 32'hFFFF) begin
      enc_scratch.insert(enc_scratch.size(), m16);
      put_be(64'(len), 2);
    end else begin
      enc_scratch.insert(enc_scratch.size(), m32);
      put_be(64'(len), 4);
    end
  endfunction

  function automatic void encode_packstream(logic [3:0] cmd, logic [63:0] v,
                                            logic [31:0] len, logic [7:0] tag);
    logic signed [63:0] sv;
    sv = v;
    enc_scratch.delete();
    case (cmd)
      CMD_NULL:   enc_scratch.insert(enc_scratch.size(), MRK_NULL);
      // bit 0 only
      CMD_BOOL:   enc_scratch.insert(enc_scratch.size(), v[0] ? MRK_TRUE : MRK_FALSE);
      CMD_INT: begin
        // smallest form that holds the signed value
        if (sv >= -16 && sv <= 127) begin
          put_be(v, 1);
        end else if (sv >= -128 && sv <= 127) begin
          enc_scratch.insert(enc_scratch.size(), MRK_INT8);
          put_be(v, 1);
        end else if (sv >= -32768 && sv <= 32767) begin
          enc_scratch.insert(enc_scratch.size(), MRK_INT16);
          put_be(v, 2);
        end else if (sv >= -64'sd2147483648 && sv <= 64'sd2147483647) begin
          enc_scratch.insert(enc_scratch.size(), MRK_INT32);
          put_be(v, 4);
        end else begin
          enc_scratch.insert(enc_scratch.size(), MRK_INT64);
          put_be(v, 8);
        end
      end
      CMD_FLOAT: begin
        enc_scratch.insert(enc_scratch.size(), MRK_FLOAT);
        put_be(v, 8);
      end
      CMD_STRING: put_sized(len, 1'b1, MRK_STR_TINY, MRK_STR8, MRK_STR16, MRK_STR32);
      CMD_BYTES:  put_sized(len, 1'b0, 8'h00, MRK_BYT8, MRK_BYT16, MRK_BYT32);
      CMD_LIST:   put_sized(len, 1'b1, MRK_LST_TINY, MRK_LST8, MRK_LST16, MRK_LST32);
      CMD_DICT:   put_sized(len, 1'b1, MRK_DCT_TINY, MRK_DCT8, MRK_DCT16, MRK_DCT32);
      CMD_STRUCT: begin
        // 32-bit struct form is an extension: 0xDE plus four length bytes
        put_sized(len, 1'b1, MRK_STC_TINY, MRK_STC8, MRK_STC16, MRK_STC32);
        enc_scratch.insert(enc_scratch.size(), tag);
      end
      CMD_RAW:    enc_scratch.insert(enc_scratch.size(), v[7:0]);
      default: ;  // unused codes produce nothing
    endcase
    foreach (enc_scratch[i])
      enc_bytes_due.insert(enc_bytes_due.size(),
                           '{enc_scratch[i], (i == enc_scratch.size() - 1)});
  endfunction

  function automatic void note_mismatch(string what, logic [8:0] want, logic [8:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
               $time, what, want[8:1], want[0], got[8:1], got[0]);
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: both handshakes sampled at the same edge, input side first,
  // so a byte can never be checked before its command has been predicted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    enc_cmd_t  cur;
    enc_byte_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        cmds_accepted++;
        codes_seen[in_if.command] = 1'b1;
        if (cmds_in_flight.size() == 0) begin
          note_mismatch("command accepted that was never offered", 'x, 'x);
        end else begin
          cur = cmds_in_flight.pop_front();
          if (cur.n_typed < 0) begin
            encode_packstream(in_if.command, in_if.value, in_if.length, in_if.tag);
          end else begin
            for (int i = cur.n_typed - 1; i >= 0; i--)
              enc_bytes_due.insert(enc_bytes_due.size(), '{cur.typed[8*i +: 8], (i == 0)});
          end
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (enc_bytes_due.size() == 0) begin
          note_mismatch("byte with nothing due", 'x, {out_if.out_byte, out_if.last});
        end else begin
          want = enc_bytes_due.pop_front();
          bytes_checked++;
          if (out_if.out_byte !== want.out_byte || out_if.last !== want.last)
            note_mismatch("wrong byte", want, {out_if.out_byte, out_if.last});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output ready: random stall bursts with calm phases, plus one long hold-off
  // on request so the descriptor queue fills and input ready drops.
  // ---------------------------------------------------------------------------
  initial begin : rx_ready_gen
    int stall_left;
    int hold_left;
    int phase_left;
    int stall_pct;
    stall_left = 0;
    hold_left  = 0;
    phase_left = 0;
    stall_pct  = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        phase_left = 50;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!tail_quiet && $urandom_range(1, 100) <= stall_pct) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Called at a clock edge; returns at the edge the transaction is accepted,
  // or later if an idle burst follows it.
  task automatic send_cmd(enc_cmd_t c);
    cmds_in_flight.insert(cmds_in_flight.size(), c);
    in_if.valid   <= 1'b1;
    in_if.command <= c.cmd;
    in_if.value   <= c.value;
    in_if.length  <= c.len;
    in_if.tag     <= c.tag;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (c.cmd < CMD_FIRST_UNUSED) items_sent++;
    if (items_sent % 16 == 0) begin
      case ($urandom_range(0, 2))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 10;
        default: tx_gap_pct = 35;
      endcase
    end
    if (!tail_quiet && !tx_no_gap && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every owed byte has come out; returns at a
  // later edge than the one it was called at.
  task automatic drain_encoder();
    in_if.valid <= 1'b0;
    do @(posedge clk_i);
    while (cmds_in_flight.size() != 0 || enc_bytes_due.size() != 0);
  endtask

  // Integers spread over every size class: full random, random magnitude by
  // arithmetic shift, and the edges between forms.
  function automatic logic [63:0] rand_int();
    logic signed [63:0] r;
    r = $signed({$urandom(), $urandom()});
    case ($urandom_range(0, 4))
      0: ;
      1, 2: r = r >>> $urandom_range(1, 63);
      default: begin
        case ($urandom_range(0, 13))
          0:  r = -16;
          1:  r = -17;
          2:  r = 127;
          3:  r = 128;
          4:  r = -128;
          5:  r = -129;
          6:  r = 32767;
          7:  r = 32768;
          8:  r = -32768;
          9:  r = -32769;
          10: r = 64'sd2147483647;
          11: r = 64'sd2147483648;
          12: r = -64'sd2147483648;
          default: r = -64'sd2147483649;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 5))
      0, 1: return 32'($urandom_range(0, 15));
      2:    return 32'($urandom_range(16, 255));
      3:    return 32'($urandom_range(256, 65535));
      4:    return $urandom();
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'd15;
          1: return 32'd16;
          2: return 32'd255;
          3: return 32'd256;
          4: return 32'd65535;
          5: return 32'd65536;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // One random value. Short string and byte headers are followed by their
  // payload as raw-byte commands, as a host would send them.
  task automatic send_random_value();
    enc_cmd_t c;
    enc_cmd_t p;
    int pick;
    c.value   = {$urandom(), $urandom()};
    c.len     = $urandom();
    c.tag     = 8'($urandom_range(0, 255));
    c.n_typed = -1;
    c.typed   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c.cmd = CMD_INT;
      c.value = rand_int();
    end else if (pick < 33) c.cmd = CMD_FLOAT;
    else if (pick < 38) c.cmd = CMD_NULL;
    else if (pick < 45) c.cmd = CMD_BOOL;
    else if (pick < 55) begin
      c.cmd = CMD_STRING;
      c.len = rand_len();
    end else if (pick < 61) begin
      c.cmd = CMD_BYTES;
      c.len = rand_len();
    end else if (pick < 68) begin
      c.cmd = CMD_LIST;
      c.len = rand_len();
    end else if (pick < 74) begin
      c.cmd = CMD_DICT;
      c.len = rand_len();
    end else if (pick < 82) begin
      c.cmd = CMD_STRUCT;
      c.len = rand_len();
    end else if (pick < 94) c.cmd = CMD_RAW;
    else c.cmd = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    send_cmd(c);
    if ((c.cmd == CMD_STRING || c.cmd == CMD_BYTES) && c.len <= 32'd8) begin
      repeat (c.len) begin
        p = c;
        p.cmd   = CMD_RAW;
        p.value = {$urandom(), $urandom()};
        p.tag   = 8'($urandom_range(0, 255));
        send_cmd(p);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    enc_cmd_t dir_cmds[N_DIRECTED];
    int       rand_base;
    bit       hold_done;
    bit       drain_done;

    hold_done  = 1'b0;
    drain_done = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.command <= CMD_NULL;
    in_if.value   <= '0;
    in_if.length  <= '0;
    in_if.tag     <= '0;
    rst_ni        <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, integer form edges, header size edges and the
    // documented corner cases. Typed bytes where they are obvious.
    dir_cmds = '{
      // null ignores all operands
      '{CMD_NULL,   64'hDEAD_BEEF_0123_4567, 32'hFFFF_FFFF, 8'hA5, 1, 72'hC0},
      '{CMD_BOOL,   64'h0,                   32'h0,         8'h00, 1, 72'hC2},
      // boolean: only bit 0 counts
      '{CMD_BOOL,   64'hFFFF_FFFF_FFFF_FFFE, 32'h0,         8'h00, 1, 72'hC2},
      '{CMD_BOOL,   64'h8000_0000_0000_0001, 32'h0,         8'h00, 1, 72'hC3},
      '{CMD_INT,    64'd127,                 32'h0,         8'h00, 1, 72'h7F},
      '{CMD_INT,    64'hFFFF_FFFF_FFFF_FFF0, 32'h0,         8'h00, 1, 72'hF0},
      '{CMD_INT,    64'hFFFF_FFFF_FFFF_FFEF, 32'h0,         8'h00, -1, 72'h0},
      '{CMD_INT,    64'd128,                 32'h0,         8'h00, -1, 72'h0},
      '{CMD_INT,    64'hFFFF_FFFF_FFFF_FF7F, 32'h0,         8'h00, -1, 72'h0},
      '{CMD_INT,    64'd32768,               32'h0,         8'h00, -1, 72'h0},
      '{CMD_INT,    64'hFFFF_FFFF_7FFF_FFFF, 32'h0,         8'h00, -1, 72'h0},
      '{CMD_INT,    64'h7FFF_FFFF_FFFF_FFFF, 32'h0,         8'h00, 9,
        72'hCB_7FFF_FFFF_FFFF_FFFF},
      '{CMD_INT,    64'h8000_0000_0000_0000, 32'h0,         8'h00, 9,
        72'hCB_8000_0000_0000_0000},
      '{CMD_FLOAT,  64'h0123_4567_89AB_CDEF, 32'h0,         8'h00, -1, 72'h0},
      '{CMD_STRING, 64'h0,                   32'd0,         8'h00, 1, 72'h80},
      '{CMD_STRING, 64'h0,                   32'd15,        8'h00, 1, 72'h8F},
      '{CMD_STRING, 64'h0,                   32'd16,        8'h00, -1, 72'h0},
      '{CMD_STRING, 64'h0,                   32'hFFFF_FFFF, 8'h00, 5, 72'hD2_FFFF_FFFF},
      // bytes has no tiny form
      '{CMD_BYTES,  64'h0,                   32'd0,         8'h00, 2, 72'hCC00},
      '{CMD_LIST,   64'h0,                   32'd255,       8'h00, -1, 72'h0},
      '{CMD_DICT,   64'h0,                   32'd256,       8'h00, -1, 72'h0},
      '{CMD_STRUCT, 64'h0,                   32'd3,         8'h4E, -1, 72'h0},
      // struct with 65536 fields takes the 32-bit extension form
      '{CMD_STRUCT, 64'h0,                   32'd65536,     8'hFF, 6, 72'hDE_0001_0000_FF},
      // raw byte passes bits 7..0 only
      '{CMD_RAW,    64'hFFFF_FFFF_FFFF_FF5A, 32'h0,         8'h00, 1, 72'h5A},
      // unused code is swallowed
      '{CMD_LAST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 0, 72'h0}
    };
    foreach (dir_cmds[i]) send_cmd(dir_cmds[i]);

    // Random part with one long output hold-off (inputs keep coming), one
    // full drain, and a tail where neither side idles.
    rand_base = items_sent;
    while (items_sent - rand_base < N_RANDOM) begin
      if (!hold_done && items_sent - rand_base >= HOLD_AT) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_no_gap   = 1'b1;
        repeat (12) send_random_value();
        tx_no_gap   = 1'b0;
      end else if (!drain_done && items_sent - rand_base >= DRAIN_AT) begin
        drain_done = 1'b1;
        drain_encoder();
        send_random_value();
      end else begin
        if (items_sent - rand_base >= QUIET_AT) tail_quiet = 1'b1;
        send_random_value();
      end
    end

    tail_quiet = 1'b1;
    drain_encoder();
    // extra bytes after the last one due would show up here
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands over %0d of 16 codes, %0d bytes checked, %0d mismatches",
             cmds_accepted, $countones(codes_seen), bytes_checked, mismatches);
    $display("Stimulus included a %0d-cycle output hold-off and a full drain mid-run",
             RX_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("packstream_value_encoder_top_tb: PASS");
    end else begin
      $display("packstream_value_encoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
